### rtl/sqb_pkg.sv
`timescale 1ns / 1ps
package sqb_pkg;

   localparam int TEX_SLOTS  = 32;
   localparam int SINE_BITS  = 10;
   localparam int SLOT_W     = $clog2(TEX_SLOTS);
   localparam int FILL_W     = $clog2(TEX_SLOTS + 1);
   localparam int QTR        = 1 << (SINE_BITS - 2);
   localparam int QIDX_W     = SINE_BITS - 1;

   localparam logic [15:0] MAX_QUADS_RESET = 16'd16384;
   localparam logic [63:0] HALF_PI_Q30     = 64'd1686629713;
   localparam logic [63:0] ONE_Q30         = 64'd1 << 30;

   localparam logic KIND_VERTEX = 1'b0;
   localparam logic KIND_DRAW   = 1'b1;
   localparam logic REQ_QUAD    = 1'b0;
   localparam logic REQ_END     = 1'b1;

   typedef logic [15:0] qsin_tab_type [0:QTR];

   typedef struct packed {
      logic              flush_only;
      logic              do_flush;
      logic [15:0]       batch_quads;
      logic [FILL_W-1:0] slot_fill;
      logic [31:0]       pos_x;
      logic [31:0]       pos_y;
      logic [31:0]       pos_z;
      logic [31:0]       size_x;
      logic [31:0]       size_y;
      logic [15:0]       sin_q;
      logic [15:0]       cos_q;
      logic [SLOT_W-1:0] slot;
      logic [31:0]       rgba;
      logic [31:0]       entity;
   } sqb_cmd_type;

   // quarter-wave sine, Q1.14, entries 0..QTR
   function automatic qsin_tab_type qsin_build();
      qsin_tab_type t;
      logic [63:0]  th;
      logic [63:0]  th2;
      logic [63:0]  acc;
      for (int x = 0; x <= QTR; x++) begin
         th  = 64'(x) * HALF_PI_Q30 / QTR;
         th2 = (th * th) >> 30;
         acc = ONE_Q30;
         acc = ONE_Q30 - ((th2 * acc) >> 30) / 110;
         acc = ONE_Q30 - ((th2 * acc) >> 30) / 72;
         acc = ONE_Q30 - ((th2 * acc) >> 30) / 42;
         acc = ONE_Q30 - ((th2 * acc) >> 30) / 20;
         acc = ONE_Q30 - ((th2 * acc) >> 30) / 6;
         t[x] = 16'(((((th * acc) >> 30) + 64'd32768) >> 16));
      end
      return t;
   endfunction

endpackage

### rtl/sprite_quad_batcher_core.sv
`timescale 1ns / 1ps
// Sprite quad batcher.
// Request words (req_valid/req_stall): a quad request yields four corner vertex
// words, preceded by one draw word when the quad budget or the texture slot
// table is full. An end-scene request yields one draw word for a non-empty batch,
// or nothing. rsp_last marks the final word of each request.
// Flow: a request is taken, classified in the next cycle (slot table search,
// sine lookup) and queued; the back end forms the four rotation products in
// PH_MUL, then emits one output word per cycle while rsp_stall is low.
// The front end takes a new request only once the last one has left DECIDE,
// which waits while the two-entry queue is full; the back end pops a new
// command only after the last word of the previous one.
// Reset clears the batch (slot fill 1, no quads) and sets the quad budget to
// 16384; csr_wr_en writes the budget; the user must do so only while idle;
// the block has no guard for it. While rsp_stall is high the output word holds
// and the back end waits; the queue then fills and req_stall rises.
module sprite_quad_batcher_core
   import sqb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [31:0] req_pos_x,
   input  logic [31:0] req_pos_y,
   input  logic [31:0] req_pos_z,
   input  logic [31:0] req_size_x,
   input  logic [31:0] req_size_y,
   input  logic [15:0] req_angle,
   input  logic        req_has_texture,
   input  logic [31:0] req_texture_id,
   input  logic [31:0] req_rgba,
   input  logic [31:0] req_entity,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [31:0] rsp_vx,
   output logic [31:0] rsp_vy,
   output logic [31:0] rsp_vz,
   output logic [31:0] rsp_vcolor,
   output logic        rsp_tex_u,
   output logic        rsp_tex_v,
   output logic [4:0]  rsp_slot,
   output logic [31:0] rsp_vert_entity,
   output logic [18:0] rsp_index_count,
   output logic [5:0]  rsp_slots_used,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic        push_valid;
   logic        push_full;
   sqb_cmd_type push_data;
   logic        pop_valid;
   logic        pop_take;
   sqb_cmd_type pop_data;

   sqb_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pos_z       (req_pos_z),
      .req_size_x      (req_size_x),
      .req_size_y      (req_size_y),
      .req_angle       (req_angle),
      .req_has_texture (req_has_texture),
      .req_texture_id  (req_texture_id),
      .req_rgba        (req_rgba),
      .req_entity      (req_entity),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .push_valid      (push_valid),
      .push_full       (push_full),
      .push_data       (push_data)
   );

   sqb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_full  (push_full),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_take   (pop_take),
      .pop_data   (pop_data)
   );

   sqb_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_take        (pop_take),
      .pop_data        (pop_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_vx          (rsp_vx),
      .rsp_vy          (rsp_vy),
      .rsp_vz          (rsp_vz),
      .rsp_vcolor      (rsp_vcolor),
      .rsp_tex_u       (rsp_tex_u),
      .rsp_tex_v       (rsp_tex_v),
      .rsp_slot        (rsp_slot),
      .rsp_vert_entity (rsp_vert_entity),
      .rsp_index_count (rsp_index_count),
      .rsp_slots_used  (rsp_slots_used),
      .rsp_last        (rsp_last)
   );

   a_draw_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_DRAW) |-> (rsp_index_count != 19'd0))
      else $error("draw word with empty batch");

   a_vert_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_VERTEX) |->
         (rsp_index_count == 19'd0) && (rsp_slots_used == 6'd0))
      else $error("vertex word carries draw fields");

   a_vert_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_VERTEX) && rsp_last |-> !rsp_tex_u && rsp_tex_v)
      else $error("last vertex is not the fourth corner");

   a_queue_full_stall: assert property (@(posedge clock) disable iff (reset)
      push_valid && push_full |=> req_stall)
      else $error("front accepted while queue full");

endmodule

### rtl/sqb_queue.sv
`timescale 1ns / 1ps
module sqb_queue
   import sqb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   output logic        push_full,
   input  sqb_cmd_type push_data,
   output logic        pop_valid,
   input  logic        pop_take,
   output sqb_cmd_type pop_data
);

   sqb_cmd_type entry_ff [0:1];
   logic [1:0]  count_ff;
   logic [1:0]  count_in;
   logic        wr_ptr_ff;
   logic        rd_ptr_ff;
   logic        do_push;
   logic        do_pop;

   assign push_full = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !push_full;
   assign do_pop    = pop_valid && pop_take;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (do_push) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= !rd_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

### rtl/sqb_front.sv
`timescale 1ns / 1ps
module sqb_front
   import sqb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [31:0] req_pos_x,
   input  logic [31:0] req_pos_y,
   input  logic [31:0] req_pos_z,
   input  logic [31:0] req_size_x,
   input  logic [31:0] req_size_y,
   input  logic [15:0] req_angle,
   input  logic        req_has_texture,
   input  logic [31:0] req_texture_id,
   input  logic [31:0] req_rgba,
   input  logic [31:0] req_entity,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   output logic        push_valid,
   input  logic        push_full,
   output sqb_cmd_type push_data
);

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_DECIDE = 1'b1;
   localparam qsin_tab_type QSIN = qsin_build();

   logic              state_ff;
   logic              state_in;
   logic [15:0]       max_ff;
   logic [15:0]       bq_ff;
   logic [15:0]       bq_in;
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic [31:0]       tab_ff [0:TEX_SLOTS-1];

   logic              h_type_ff;
   logic [31:0]       h_px_ff, h_py_ff, h_pz_ff, h_sx_ff, h_sy_ff;
   logic [15:0]       h_angle_ff;
   logic              h_tex_ff;
   logic [31:0]       h_tid_ff, h_rgba_ff, h_ent_ff;

   logic              accept;
   logic              advance;
   logic              budget;
   logic [FILL_W-1:0] fill1;
   logic [FILL_W-1:0] fill2;
   logic [TEX_SLOTS-1:0] hit;
   logic              found;
   logic [SLOT_W-1:0] hit_slot;
   logic              new_tex;
   logic              sfull;
   logic              flush_any;
   logic [SLOT_W-1:0] slot;
   logic [SINE_BITS-1:0] k_sin;
   logic [SINE_BITS-1:0] k_cos;
   logic [15:0]       sin_q;
   logic [15:0]       cos_q;

   function automatic logic [15:0] sine_of(input logic [SINE_BITS-1:0] k);
      logic [1:0]        quad;
      logic [QIDX_W-1:0] r;
      logic [QIDX_W-1:0] idx;
      logic [15:0]       v;
      quad = k[SINE_BITS-1 -: 2];
      r    = {1'b0, k[SINE_BITS-3:0]};
      idx  = quad[0] ? (QIDX_W'(QTR) - r) : r;
      v    = QSIN[idx];
      return quad[1] ? (16'd0 - v) : v;
   endfunction

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      budget = (h_type_ff == REQ_QUAD) && (bq_ff >= max_ff);
      fill1  = budget ? FILL_W'(1) : fill_ff;
      for (int j = 0; j < TEX_SLOTS; j++) begin
         hit[j] = (j != 0) && (FILL_W'(j) < fill1) && (tab_ff[j] == h_tid_ff);
      end
      found    = |hit;
      hit_slot = '0;
      for (int j = TEX_SLOTS - 1; j > 0; j--) begin
         if (hit[j]) hit_slot = SLOT_W'(j);
      end
      new_tex   = h_tex_ff && !found;
      sfull     = new_tex && (fill1 >= FILL_W'(TEX_SLOTS));
      fill2     = sfull ? FILL_W'(1) : fill1;
      flush_any = budget || sfull;
      if (!h_tex_ff) begin
         slot = '0;
      end else if (found) begin
         slot = hit_slot;
      end else begin
         slot = SLOT_W'(fill2);
      end
      k_sin = h_angle_ff[15 -: SINE_BITS];
      k_cos = k_sin + SINE_BITS'(QTR);
      sin_q = sine_of(k_sin);
      cos_q = sine_of(k_cos);
   end

   always_comb begin
      push_data.flush_only  = (h_type_ff == REQ_END);
      push_data.do_flush    = (h_type_ff == REQ_END) || (flush_any && (bq_ff != 16'd0));
      push_data.batch_quads = bq_ff;
      push_data.slot_fill   = fill_ff;
      push_data.pos_x       = h_px_ff;
      push_data.pos_y       = h_py_ff;
      push_data.pos_z       = h_pz_ff;
      push_data.size_x      = h_sx_ff;
      push_data.size_y      = h_sy_ff;
      push_data.sin_q       = sin_q;
      push_data.cos_q       = cos_q;
      push_data.slot        = slot;
      push_data.rgba        = h_rgba_ff;
      push_data.entity      = h_ent_ff;
   end

   always_comb begin
      push_valid = (state_ff == ST_DECIDE) &&
                   ((h_type_ff == REQ_QUAD) || (bq_ff != 16'd0));
      advance    = (state_ff == ST_DECIDE) && !(push_valid && push_full);
      state_in   = state_ff;
      bq_in      = bq_ff;
      fill_in    = fill_ff;
      if (accept) state_in = ST_DECIDE;
      if (advance) begin
         state_in = ST_IDLE;
         if (h_type_ff == REQ_END) begin
            bq_in   = 16'd0;
            fill_in = FILL_W'(1);
         end else begin
            bq_in   = (flush_any ? 16'd0 : bq_ff) + 16'd1;
            fill_in = new_tex ? (fill2 + FILL_W'(1)) : fill1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         bq_ff    <= 16'd0;
         fill_ff  <= FILL_W'(1);
         max_ff   <= MAX_QUADS_RESET;
      end else begin
         state_ff <= state_in;
         bq_ff    <= bq_in;
         fill_ff  <= fill_in;
         if (csr_wr_en) max_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         h_type_ff  <= req_type;
         h_px_ff    <= req_pos_x;
         h_py_ff    <= req_pos_y;
         h_pz_ff    <= req_pos_z;
         h_sx_ff    <= req_size_x;
         h_sy_ff    <= req_size_y;
         h_angle_ff <= req_angle;
         h_tex_ff   <= req_has_texture;
         h_tid_ff   <= req_texture_id;
         h_rgba_ff  <= req_rgba;
         h_ent_ff   <= req_entity;
      end
      if (advance && (h_type_ff == REQ_QUAD) && new_tex) begin
         tab_ff[SLOT_W'(fill2)] <= h_tid_ff;
      end
   end

endmodule

### rtl/sqb_back.sv
`timescale 1ns / 1ps
module sqb_back
   import sqb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        pop_valid,
   output logic        pop_take,
   input  sqb_cmd_type pop_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [31:0] rsp_vx,
   output logic [31:0] rsp_vy,
   output logic [31:0] rsp_vz,
   output logic [31:0] rsp_vcolor,
   output logic        rsp_tex_u,
   output logic        rsp_tex_v,
   output logic [4:0]  rsp_slot,
   output logic [31:0] rsp_vert_entity,
   output logic [18:0] rsp_index_count,
   output logic [5:0]  rsp_slots_used,
   output logic        rsp_last
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_MUL  = 2'd1;
   localparam logic [1:0] PH_DRAW = 2'd2;
   localparam logic [1:0] PH_VERT = 2'd3;

   sqb_cmd_type        cmd_ff;
   logic [1:0]         phase_ff;
   logic [1:0]         corner_ff;
   logic signed [47:0] pa_ff, pb_ff, pc_ff, pd_ff;
   logic               out_free;
   logic               load_draw;
   logic               load_vert;
   logic               neg_x, neg_y;
   logic signed [49:0] tx, ty;
   logic [31:0]        vx, vy;

   function automatic logic [31:0] sat_add(input logic [31:0] p, input logic signed [49:0] t);
      logic signed [49:0] r;
      logic signed [50:0] s;
      r = (t + 50'sd16384) >>> 15;
      s = 51'(signed'(p)) + 51'(r);
      if (s > 51'sd2147483647) return 32'h7fffffff;
      if (s < -51'sd2147483648) return 32'h80000000;
      return s[31:0];
   endfunction

   assign out_free  = !rsp_valid || !rsp_stall;
   assign pop_take  = (phase_ff == PH_IDLE);
   assign load_draw = (phase_ff == PH_DRAW) && out_free;
   assign load_vert = (phase_ff == PH_VERT) && out_free;

   always_comb begin
      neg_x = (corner_ff == 2'd0) || (corner_ff == 2'd3);
      neg_y = !corner_ff[1];
      tx = (neg_x ? -50'(pa_ff) : 50'(pa_ff)) + (neg_y ? 50'(pb_ff) : -50'(pb_ff));
      ty = (neg_x ? -50'(pc_ff) : 50'(pc_ff)) + (neg_y ? -50'(pd_ff) : 50'(pd_ff));
      vx = sat_add(cmd_ff.pos_x, tx);
      vy = sat_add(cmd_ff.pos_y, ty);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         corner_ff <= 2'd0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= load_draw || load_vert || (rsp_valid && rsp_stall);
         case (phase_ff)
            PH_IDLE: begin
               if (pop_valid) phase_ff <= pop_data.flush_only ? PH_DRAW : PH_MUL;
               corner_ff <= 2'd0;
            end
            PH_MUL: begin
               phase_ff <= cmd_ff.do_flush ? PH_DRAW : PH_VERT;
            end
            PH_DRAW: begin
               if (out_free) begin
                  phase_ff <= cmd_ff.flush_only ? PH_IDLE : PH_VERT;
               end
            end
            PH_VERT: begin
               if (out_free) begin
                  corner_ff <= corner_ff + 2'd1;
                  if (corner_ff == 2'd3) phase_ff <= PH_IDLE;
               end
            end
            default: phase_ff <= PH_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if ((phase_ff == PH_IDLE) && pop_valid) cmd_ff <= pop_data;
      if (phase_ff == PH_MUL) begin
         pa_ff <= signed'(cmd_ff.cos_q) * signed'(cmd_ff.size_x);
         pb_ff <= signed'(cmd_ff.sin_q) * signed'(cmd_ff.size_y);
         pc_ff <= signed'(cmd_ff.sin_q) * signed'(cmd_ff.size_x);
         pd_ff <= signed'(cmd_ff.cos_q) * signed'(cmd_ff.size_y);
      end
      if (load_draw) begin
         rsp_kind        <= KIND_DRAW;
         rsp_vx          <= '0;
         rsp_vy          <= '0;
         rsp_vz          <= '0;
         rsp_vcolor      <= '0;
         rsp_tex_u       <= 1'b0;
         rsp_tex_v       <= 1'b0;
         rsp_slot        <= '0;
         rsp_vert_entity <= '0;
         rsp_index_count <= 19'(cmd_ff.batch_quads) * 19'd6;
         rsp_slots_used  <= 6'(cmd_ff.slot_fill);
         rsp_last        <= cmd_ff.flush_only;
      end else if (load_vert) begin
         rsp_kind        <= KIND_VERTEX;
         rsp_vx          <= vx;
         rsp_vy          <= vy;
         rsp_vz          <= cmd_ff.pos_z;
         rsp_vcolor      <= cmd_ff.rgba;
         rsp_tex_u       <= corner_ff[0] ^ corner_ff[1];
         rsp_tex_v       <= corner_ff[1];
         rsp_slot        <= 5'(cmd_ff.slot);
         rsp_vert_entity <= cmd_ff.entity;
         rsp_index_count <= '0;
         rsp_slots_used  <= '0;
         rsp_last        <= (corner_ff == 2'd3);
      end
   end

endmodule

### test/sprite_quad_batcher_core_test.sv
`timescale 1ns / 1ps
module sprite_quad_batcher_core_test;
   import sqb_pkg::*;

   typedef struct {
      logic        rtype;
      logic [31:0] px, py, pz, sx, sy;
      logic [15:0] ang;
      logic        has_tex;
      logic [31:0] tid, rgba, ent;
   } sprite_req_type;

   typedef struct {
      logic        kind;
      logic [31:0] vx, vy, vz, color;
      logic        u, v;
      logic [4:0]  slot;
      logic [31:0] ent;
      logic [18:0] idx;
      logic [5:0]  used;
      logic        last;
   } quad_word_type;

   typedef struct {
      sprite_req_type r;
      int             typed_idx;  // -1: predictor decides
      int             typed_used;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_type = 1'b0;
   logic [31:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic [31:0] req_size_x = '0, req_size_y = '0;
   logic [15:0] req_angle = '0;
   logic        req_has_texture = 1'b0;
   logic [31:0] req_texture_id = '0, req_rgba = '0, req_entity = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_kind;
   logic [31:0] rsp_vx, rsp_vy, rsp_vz, rsp_vcolor;
   logic        rsp_tex_u, rsp_tex_v;
   logic [4:0]  rsp_slot;
   logic [31:0] rsp_vert_entity;
   logic [18:0] rsp_index_count;
   logic [5:0]  rsp_slots_used;
   logic        rsp_last;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;

   sprite_quad_batcher_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .req_size_x(req_size_x), .req_size_y(req_size_y), .req_angle(req_angle),
      .req_has_texture(req_has_texture), .req_texture_id(req_texture_id),
      .req_rgba(req_rgba), .req_entity(req_entity),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_kind(rsp_kind),
      .rsp_vx(rsp_vx), .rsp_vy(rsp_vy), .rsp_vz(rsp_vz), .rsp_vcolor(rsp_vcolor),
      .rsp_tex_u(rsp_tex_u), .rsp_tex_v(rsp_tex_v), .rsp_slot(rsp_slot),
      .rsp_vert_entity(rsp_vert_entity), .rsp_index_count(rsp_index_count),
      .rsp_slots_used(rsp_slots_used), .rsp_last(rsp_last),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state
   longint        sine_lut [0:1023];
   logic [31:0]   bound_tex [0:TEX_SLOTS-1];
   int            fill_cnt;
   int            quad_cnt;
   int            quad_budget;
   quad_word_type pending_words [$];

   int  errors = 0;
   int  cycles = 0;
   bit  quiet = 0;
   int  hold_cycles = 0;

   function automatic longint quarter_wave(longint unsigned x);
      longint unsigned th, th2, acc;
      longint unsigned divs [5] = '{110, 72, 42, 20, 6};
      th  = x * 64'd1686629713 / 256;
      th2 = (th * th) >> 30;
      acc = 64'd1 << 30;
      for (int i = 0; i < 5; i++)
         acc = (64'd1 << 30) - ((th2 * acc) >> 30) / divs[i];
      return longint'((((th * acc) >> 30) + 64'd32768) >> 16);
   endfunction

   function automatic logic [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   function automatic void push_draw(logic last);
      quad_word_type w;
      if (quad_cnt != 0) begin
         w = '{default: '0};
         w.kind = KIND_DRAW;
         w.idx  = 19'(quad_cnt * 6);
         w.used = 6'(fill_cnt);
         w.last = last;
         pending_words.push_back(w);
      end
      quad_cnt = 0;
      fill_cnt = 1;
   endfunction

   function automatic void predict_words(sprite_req_type r);
      int            slot_no;
      int            csx [4] = '{-1, 1, 1, -1};
      int            csy [4] = '{-1, -1, 1, 1};
      int            k;
      longint        s, c, lx, ly, tx, ty;
      quad_word_type w;
      slot_no = 0;
      if (r.rtype == REQ_END) begin
         push_draw(1'b1);
         return;
      end
      if (quad_cnt >= quad_budget) push_draw(1'b0);
      if (r.has_tex) begin
         for (int j = 1; j < fill_cnt && j < TEX_SLOTS; j++)
            if (slot_no == 0 && bound_tex[j] == r.tid) slot_no = j;
         if (slot_no == 0) begin
            if (fill_cnt >= TEX_SLOTS) push_draw(1'b0);
            slot_no = fill_cnt;
            bound_tex[fill_cnt] = r.tid;
            fill_cnt++;
         end
      end
      k = r.ang >> 6;
      s = sine_lut[k];
      c = sine_lut[(k + 256) % 1024];
      for (int i = 0; i < 4; i++) begin
         lx = csx[i] * longint'(signed'(r.sx));
         ly = csy[i] * longint'(signed'(r.sy));
         tx = c * lx - s * ly;
         ty = s * lx + c * ly;
         w.kind  = KIND_VERTEX;
         w.vx    = clamp32(longint'(signed'(r.px)) + ((tx + 16384) >>> 15));
         w.vy    = clamp32(longint'(signed'(r.py)) + ((ty + 16384) >>> 15));
         w.vz    = r.pz;
         w.color = r.rgba;
         w.u     = (i == 1 || i == 2);
         w.v     = (i >= 2);
         w.slot  = 5'(slot_no);
         w.ent   = r.ent;
         w.idx   = '0;
         w.used  = '0;
         w.last  = (i == 3);
         pending_words.push_back(w);
      end
      quad_cnt++;
   endfunction

   task automatic send(stim_row_type row);
      int before_sz;
      req_valid       <= 1'b1;
      req_type        <= row.r.rtype;
      req_pos_x       <= row.r.px;
      req_pos_y       <= row.r.py;
      req_pos_z       <= row.r.pz;
      req_size_x      <= row.r.sx;
      req_size_y      <= row.r.sy;
      req_angle       <= row.r.ang;
      req_has_texture <= row.r.has_tex;
      req_texture_id  <= row.r.tid;
      req_rgba        <= row.r.rgba;
      req_entity      <= row.r.ent;
      do @(posedge clock); while (req_stall);
      before_sz = pending_words.size();
      predict_words(row.r);
      if (row.typed_idx >= 0) begin
         if (pending_words.size() == before_sz) begin
            errors++;
            $display("%0t: typed draw expected, none predicted", $time);
         end else begin
            pending_words[$].idx  = 19'(row.typed_idx);
            pending_words[$].used = 6'(row.typed_used);
         end
      end
      if (!quiet && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_budget(logic [15:0] val);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      quad_budget = (val == 0) ? 1 : val;
   endtask

   function automatic stim_row_type mk(logic rtype, logic [31:0] px, logic [31:0] py,
                                       logic [31:0] sx, logic [31:0] sy, logic [15:0] ang,
                                       logic has_tex, logic [31:0] tid,
                                       int typed_idx = -1, int typed_used = 0);
      stim_row_type row;
      row.r = '{rtype, px, py, $urandom, sx, sy, ang, has_tex, tid, $urandom, $urandom};
      row.typed_idx  = typed_idx;
      row.typed_used = typed_used;
      return row;
   endfunction

   function automatic stim_row_type rand_row(int tex_base);
      stim_row_type row;
      row.r.rtype   = ($urandom_range(99) < 7) ? REQ_END : REQ_QUAD;
      row.r.px      = $urandom;
      row.r.py      = $urandom;
      row.r.pz      = $urandom;
      if ($urandom_range(3) == 0) begin
         row.r.sx = $urandom;
         row.r.sy = $urandom;
      end else begin
         row.r.sx = 32'(signed'($urandom_range(0, 2 << 22)) - (1 << 22));
         row.r.sy = 32'(signed'($urandom_range(0, 2 << 22)) - (1 << 22));
      end
      row.r.ang     = $urandom;
      row.r.has_tex = $urandom_range(99) < 75;
      row.r.tid     = ($urandom_range(9) == 0) ? $urandom
                                               : 32'(tex_base + $urandom_range(0, 40));
      row.r.rgba    = $urandom;
      row.r.ent     = $urandom;
      row.typed_idx = -1;
      return row;
   endfunction

   stim_row_type directed [$];

   initial begin
      int q, r;
      logic [15:0] budgets [6];
      for (int k = 0; k < 1024; k++) begin
         q = k / 256;
         r = k % 256;
         case (q)
            0: sine_lut[k] = quarter_wave(r);
            1: sine_lut[k] = quarter_wave(256 - r);
            2: sine_lut[k] = -quarter_wave(r);
            default: sine_lut[k] = -quarter_wave(256 - r);
         endcase
      end
      fill_cnt    = 1;
      quad_cnt    = 0;
      quad_budget = 16384;

      // end scene on empty batch, quads with and without texture, slot reuse
      directed.push_back(mk(REQ_END, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(mk(REQ_QUAD, 0, 0, 32'h0001_0000, 32'h0001_0000, 16'h0000, 0, 0));
      directed.push_back(mk(REQ_QUAD, 0, 0, 32'h0002_0000, 32'h0001_0000, 16'h4000, 1, 32'hA));
      directed.push_back(mk(REQ_QUAD, 0, 0, 32'h0001_0000, 32'h0003_0000, 16'h8000, 1, 32'hA));
      directed.push_back(mk(REQ_QUAD, 0, 0, 32'h0001_0000, 32'h0001_0000, 16'hC000, 1,
                            32'hFFFF_FFFF));
      directed.push_back(mk(REQ_END, 0, 0, 0, 0, 0, 0, 0, 24, 3));
      // saturation at both ends, extreme sizes and angles
      directed.push_back(mk(REQ_QUAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF, 16'hFFFF, 0, 0));
      directed.push_back(mk(REQ_QUAD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 16'h2000, 1, 0));
      directed.push_back(mk(REQ_QUAD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h8000_0000, 16'h003F, 1, 0));
      directed.push_back(mk(REQ_QUAD, 0, 0, 32'hFFFF_FFFF, 32'h0000_0001, 16'h0040, 1, 1));
      directed.push_back(mk(REQ_END, 0, 0, 0, 0, 0, 0, 0, 24, 3));
      directed.push_back(mk(REQ_END, 0, 0, 0, 0, 0, 0, 0));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send(directed[i]);
      drain();
      write_budget(16'd1);
      directed.delete();
      // budget of one: every quad after the first forces a draw
      directed.push_back(mk(REQ_QUAD, 32'h10000, 0, 32'h10000, 32'h10000, 16'h1234, 1, 5));
      directed.push_back(mk(REQ_QUAD, 0, 32'h10000, 32'h10000, 32'h10000, 16'h9999, 1, 6));
      directed.push_back(mk(REQ_QUAD, 0, 0, 32'h10000, 32'h10000, 16'h7777, 0, 0));
      directed.push_back(mk(REQ_END, 0, 0, 0, 0, 0, 0, 0, 6, 1));
      foreach (directed[i]) send(directed[i]);
      drain();

      budgets = '{16'd3, 16'd65535, 16'd0, 16'd7, 16'd1, 16'd16384};
      foreach (budgets[p]) begin
         write_budget(budgets[p]);
         for (int i = 0; i < 48; i++) begin
            quiet = (p == 1);
            if (p == 3 && i == 10) hold_cycles = 120;
            if (p == 4 && i == 20) begin
               req_valid <= 1'b0;
               while (pending_words.size() != 0) @(posedge clock);
            end
            send(rand_row(p * 1000));
         end
         quiet = 0;
         send(mk(REQ_END, 0, 0, 0, 0, 0, 0, 0));
         drain();
      end

      repeat (30) @(posedge clock);
      if (errors == 0 && pending_words.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else if (quiet || reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(99) < 13);
   end

   function automatic void cmp(string name, longint unsigned e, longint unsigned a);
      if (e != a) begin
         errors++;
         $display("%0t: %s expected %0h got %0h", $time, name, e, a);
      end
   endfunction

   always @(posedge clock) begin
      quad_word_type w;
      cycles++;
      if (cycles > 200000) begin
         $display("TB_ERROR");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_words.size() == 0) begin
            errors++;
            $display("%0t: unexpected word, expected none got kind %0d", $time, rsp_kind);
         end else begin
            w = pending_words.pop_front();
            cmp("kind", w.kind, rsp_kind);
            cmp("vx", w.vx, rsp_vx);
            cmp("vy", w.vy, rsp_vy);
            cmp("vz", w.vz, rsp_vz);
            cmp("vcolor", w.color, rsp_vcolor);
            cmp("tex_u", w.u, rsp_tex_u);
            cmp("tex_v", w.v, rsp_tex_v);
            cmp("slot", w.slot, rsp_slot);
            cmp("vert_entity", w.ent, rsp_vert_entity);
            cmp("index_count", w.idx, rsp_index_count);
            cmp("slots_used", w.used, rsp_slots_used);
            cmp("last", w.last, rsp_last);
         end
      end
   end

endmodule
